/* sv/kwsm_pkg.sv */
package kwsm_pkg;

    // fixed field widths of the stream payload
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int S_USER_W = FUNC_W + IDX_W;

    // parameter defaults
    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes carried in s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH  = 2'd0,
        FN_POP   = 2'd1,
        FN_CLEAR = 2'd2
    } func_t;

    // result codes carried in m_tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_ERR   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } merge_state_t;

endpackage

/* sv/k_way_sorted_merge.sv */
// push, clear, unused code and a pop with the order error set: result in the cycle after the transfer
// a pop otherwise scans the list heads through one memory read port and one shared compare:
// each head is read in turn and compared with the running minimum, then the winning list advances
// one push or clear per cycle unless the output stalls; s_tready is low
// while a pop scan runs; aresetn (synchronous, active low) empties all lists and clears the
// order error; the element memory itself is not cleared and needs no clearing pass
module k_way_sorted_merge import kwsm_pkg::*; #(
    parameter int NUM_LISTS  = NUM_LISTS_DEF,
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic [S_USER_W-1:0] s_tuser,   // [1:0] func, [4:2] list_index
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [VALUE_W-1:0]  m_tdata,   // [31:0] out_value
    output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

    localparam int LW        = $clog2(NUM_LISTS);
    localparam int AW        = $clog2(LIST_DEPTH);
    localparam int MW        = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int MEM_DEPTH = NUM_LISTS * (2 ** AW);
    localparam logic [AW-1:0] LAST_ADDR = AW'(LIST_DEPTH - 1);
    localparam logic [LW:0]   LISTS_CNT = (LW + 1)'(NUM_LISTS);

    merge_state_t state_reg, state_next;

    // per-list pointers: address plus wrap phase
    logic [AW-1:0]         rd_addr_reg [NUM_LISTS];
    logic [AW-1:0]         rd_addr_next[NUM_LISTS];
    logic                  rd_ph_reg   [NUM_LISTS];
    logic                  rd_ph_next  [NUM_LISTS];
    logic [AW-1:0]         wr_addr_reg [NUM_LISTS];
    logic [AW-1:0]         wr_addr_next[NUM_LISTS];
    logic                  wr_ph_reg   [NUM_LISTS];
    logic                  wr_ph_next  [NUM_LISTS];
    logic [DATA_WIDTH-1:0] last_reg    [NUM_LISTS];
    logic [DATA_WIDTH-1:0] last_next   [NUM_LISTS];

    logic                  err_reg, err_next;
    logic [LW:0]           cnt_reg, cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [LW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  found_reg, found_next;
    logic [LW-1:0]         best_idx_reg, best_idx_next;
    logic [DATA_WIDTH-1:0] best_val_reg, best_val_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [VALUE_W-1:0]    out_data_reg, out_data_next;

    // element memory
    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
    logic                  mem_we, mem_re;
    logic [LW+AW-1:0]      mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] rdata_reg;

    // decoded request
    func_t                 req_func;
    logic [IDX_W-1:0]      req_idx;
    logic                  in_range;
    logic [LW-1:0]         ptr_sel;
    logic                  sel_empty, sel_full, order_bad, accept;
    logic [MW-1:0]         val_wide, best_wide;
    logic [DATA_WIDTH-1:0] val_dw;

    assign req_func = func_t'(s_tuser[FUNC_W-1:0]);
    assign req_idx  = s_tuser[S_USER_W-1:FUNC_W];
    assign in_range = {{(32 - IDX_W){1'b0}}, req_idx} < 32'(NUM_LISTS);
    assign val_wide = MW'(s_tdata);
    assign val_dw   = val_wide[DATA_WIDTH-1:0];
    assign best_wide = MW'(best_val_reg);

    // one pointer lookup shared by push and scan
    assign ptr_sel   = (state_reg == ST_SCAN) ? cnt_reg[LW-1:0] : LW'(req_idx);
    assign sel_empty = (rd_addr_reg[ptr_sel] == wr_addr_reg[ptr_sel])
                    && (rd_ph_reg[ptr_sel] == wr_ph_reg[ptr_sel]);
    assign sel_full  = (rd_addr_reg[ptr_sel] == wr_addr_reg[ptr_sel])
                    && (rd_ph_reg[ptr_sel] != wr_ph_reg[ptr_sel]);
    assign order_bad = !sel_empty && ($signed(val_dw) < $signed(last_reg[ptr_sel]));

    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign mem_waddr = {ptr_sel, wr_addr_reg[ptr_sel]};
    assign mem_raddr = {ptr_sel, rd_addr_reg[ptr_sel]};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // sequencer: next state and datapath control
    always_comb begin
        state_next      = state_reg;
        rd_addr_next    = rd_addr_reg;
        rd_ph_next      = rd_ph_reg;
        wr_addr_next    = wr_addr_reg;
        wr_ph_next      = wr_ph_reg;
        last_next       = last_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_data_next   = '0;
                    case (req_func)
                        FN_PUSH: begin
                            if (!in_range || sel_full) begin
                                out_status_next = STAT_FULL;
                            end else if (order_bad) begin
                                err_next        = 1'b1;
                                out_status_next = STAT_ERR;
                            end else begin
                                mem_we             = 1'b1;
                                last_next[ptr_sel] = val_dw;
                                if (wr_addr_reg[ptr_sel] == LAST_ADDR) begin
                                    wr_addr_next[ptr_sel] = '0;
                                    wr_ph_next[ptr_sel]   = !wr_ph_reg[ptr_sel];
                                end else begin
                                    wr_addr_next[ptr_sel] = wr_addr_reg[ptr_sel] + 1'b1;
                                end
                            end
                        end
                        FN_POP: begin
                            if (err_reg) begin
                                out_status_next = STAT_ERR;
                            end else begin
                                out_valid_next  = 1'b0;
                                state_next      = ST_SCAN;
                                cnt_next        = '0;
                                found_next      = 1'b0;
                                pend_valid_next = 1'b0;
                            end
                        end
                        FN_CLEAR: begin
                            for (int i = 0; i < NUM_LISTS; i++) begin
                                rd_addr_next[i] = '0;
                                rd_ph_next[i]   = 1'b0;
                                wr_addr_next[i] = '0;
                                wr_ph_next[i]   = 1'b0;
                            end
                            err_next = 1'b0;
                        end
                        default: begin
                            out_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // compare the head read last cycle against the running minimum
                if (pend_valid_reg
                    && (!found_reg || ($signed(rdata_reg) < $signed(best_val_reg)))) begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_val_next = rdata_reg;
                end
                // fetch the next list head
                if (cnt_reg < LISTS_CNT) begin
                    mem_re          = 1'b1;
                    pend_valid_next = !sel_empty;
                    pend_idx_next   = ptr_sel;
                    cnt_next        = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                out_valid_next = 1'b1;
                if (found_reg) begin
                    out_status_next = STAT_OK;
                    out_data_next   = best_wide[VALUE_W-1:0];
                    if (rd_addr_reg[best_idx_reg] == LAST_ADDR) begin
                        rd_addr_next[best_idx_reg] = '0;
                        rd_ph_next[best_idx_reg]   = !rd_ph_reg[best_idx_reg];
                    end else begin
                        rd_addr_next[best_idx_reg] = rd_addr_reg[best_idx_reg] + 1'b1;
                    end
                end else begin
                    out_status_next = STAT_EMPTY;
                    out_data_next   = '0;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                rd_addr_reg[i] <= '0;
                rd_ph_reg[i]   <= 1'b0;
                wr_addr_reg[i] <= '0;
                wr_ph_reg[i]   <= 1'b0;
            end
            err_reg        <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
        end else begin
            rd_addr_reg    <= rd_addr_next;
            rd_ph_reg      <= rd_ph_next;
            wr_addr_reg    <= wr_addr_next;
            wr_ph_reg      <= wr_ph_next;
            err_reg        <= err_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        last_reg     <= last_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        out_data_reg <= out_data_next;
    end

    // element memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= val_dw;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // no new transfer while a pop scan is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken during pop scan");

    // the end of a scan always presents a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("pop result missing after scan");

    // a store never lands in a full list
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (!sel_full && (state_reg == ST_IDLE)))
        else $error("write into full list");

    // the winning list still holds its head when it is popped
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && found_reg) |->
            !((rd_addr_reg[best_idx_reg] == wr_addr_reg[best_idx_reg])
              && (rd_ph_reg[best_idx_reg] == wr_ph_reg[best_idx_reg])))
        else $error("pop from empty list");

    // an order error blocks every ok pop result
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && (cnt_reg == '0)) |-> !err_reg)
        else $error("scan started with order error set");

endmodule

/* tb/tb.sv */
module tb;
    import kwsm_pkg::*;

    localparam int NL    = NUM_LISTS_DEF;
    localparam int LD    = LIST_DEPTH_DEF;
    localparam int PTR_W = $clog2(2 * LD);

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] value;
    } merge_op_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] value;
    } merge_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [VALUE_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    k_way_sorted_merge #(
        .NUM_LISTS (NUM_LISTS_DEF),
        .LIST_DEPTH(LIST_DEPTH_DEF),
        .DATA_WIDTH(DATA_WIDTH_DEF)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state: the lists, their pointers, last pushed values, order flag
    logic signed [VALUE_W-1:0] lst_store [NL][LD];
    logic [PTR_W-1:0]          rd_ptr [NL];
    logic [PTR_W-1:0]          wr_ptr [NL];
    logic signed [VALUE_W-1:0] tail_val [NL];
    bit                        order_err;

    merge_op_t  op_queue[$];
    merge_res_t predicted_results[$];
    merge_op_t  cur_op;
    int         sent_cnt = 0;
    int         fail_cnt = 0;
    logic       quiet;

    // stretch with no idling on either side
    assign quiet = (sent_cnt >= 300) && (sent_cnt < 450);

    // forget every list and the order flag
    function automatic void lists_clear();
        for (int i = 0; i < NL; i++) begin
            rd_ptr[i]   = '0;
            wr_ptr[i]   = '0;
            tail_val[i] = '0;
        end
        order_err = 1'b0;
    endfunction

    // expected answer of one operation, updating the predicted lists
    function automatic merge_res_t merge_predict(input merge_op_t op);
        merge_res_t                r;
        logic [PTR_W-1:0]          cnt;
        int                        best;
        logic signed [VALUE_W-1:0] best_v;
        logic signed [VALUE_W-1:0] head;
        bit                        found;
        r.status = STAT_OK;
        r.value  = '0;
        found    = 1'b0;
        best     = 0;
        best_v   = '0;
        case (op.func)
            FN_PUSH: begin
                if (op.idx >= NL) begin
                    r.status = STAT_FULL;
                end else begin
                    cnt = wr_ptr[op.idx] - rd_ptr[op.idx];
                    if (cnt >= LD) begin
                        r.status = STAT_FULL;
                    end else if (cnt != 0 && op.value < tail_val[op.idx]) begin
                        order_err = 1'b1;
                        r.status  = STAT_ERR;
                    end else begin
                        lst_store[op.idx][wr_ptr[op.idx][PTR_W-2:0]] = op.value;
                        wr_ptr[op.idx]   = wr_ptr[op.idx] + 1'b1;
                        tail_val[op.idx] = op.value;
                    end
                end
            end
            FN_POP: begin
                if (order_err) begin
                    r.status = STAT_ERR;
                end else begin
                    // strict compare keeps the lowest index on a tie
                    for (int i = 0; i < NL; i++) begin
                        if (rd_ptr[i] != wr_ptr[i]) begin
                            head = lst_store[i][rd_ptr[i][PTR_W-2:0]];
                            if (!found || head < best_v) begin
                                found  = 1'b1;
                                best   = i;
                                best_v = head;
                            end
                        end
                    end
                    if (!found) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        rd_ptr[best] = rd_ptr[best] + 1'b1;
                        r.value      = best_v;
                    end
                end
            end
            FN_CLEAR: begin
                lists_clear();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // driver: predicts each transfer, then presents the next pending operation
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_results.push_back(merge_predict(cur_op));
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 33)) begin
                    cur_op = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_op.value;
                    s_tuser  <= {cur_op.idx, cur_op.func};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, field checks against the oldest prediction
    always @(posedge aclk) begin
        merge_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 33);
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result: status %0d, out_value %0d",
                           m_tuser, $signed(m_tdata));
                    fail_cnt++;
                end else begin
                    want = predicted_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("out_value: expected %0d, actual %0d",
                               want.value, $signed(m_tdata));
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // stimulus generator state: a rough idea of each list's tail
    longint gen_last [NL];
    bit     gen_has [NL];
    int     gen_cnt = 0;

    task automatic add_op(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                          input logic [VALUE_W-1:0] v);
        merge_op_t op;
        op.func  = f;
        op.idx   = idx;
        op.value = v;
        op_queue.push_back(op);
        gen_cnt++;
        if (f == FN_CLEAR) begin
            for (int i = 0; i < NL; i++) gen_has[i] = 1'b0;
        end
    endtask

    // in-order push: a fresh random start, then non-decreasing steps
    task automatic push_sorted(input int l, input int max_step);
        longint nv;
        if (!gen_has[l]) begin
            nv = longint'($signed($urandom()));
        end else if ($urandom_range(0, 3) == 0) begin
            nv = gen_last[l];
        end else begin
            nv = gen_last[l] + $urandom_range(1, max_step);
            if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        end
        gen_last[l] = nv;
        gen_has[l]  = 1'b1;
        add_op(FN_PUSH, l[IDX_W-1:0], nv[VALUE_W-1:0]);
    endtask

    task automatic push_out_of_order(input int l);
        longint nv;
        if (!gen_has[l]) begin
            push_sorted(l, 1000);
        end else begin
            nv = gen_last[l] - $urandom_range(1, 1000);
            if (nv < -64'sd2147483648) nv = -64'sd2147483648;
            add_op(FN_PUSH, l[IDX_W-1:0], nv[VALUE_W-1:0]);
        end
    endtask

    task automatic add_pop();
        add_op(FN_POP, IDX_W'($urandom_range(0, 7)), $urandom());
    endtask

    initial begin
        int n;
        int r;
        int l;
        lists_clear();
        for (int i = 0; i < NL; i++) gen_has[i] = 1'b0;

        // directed: empty pop, unused code, extremes, ties, order error, clear
        add_pop();
        add_op(2'd3, 3'd5, 32'hdead_beef);
        add_op(FN_PUSH, 3'd0, 32'h8000_0000);
        add_op(FN_PUSH, 3'd7, 32'h7fff_ffff);
        add_op(FN_PUSH, 3'd3, 32'h0000_0000);
        add_op(FN_PUSH, 3'd3, 32'h0000_0000);
        add_op(FN_PUSH, 3'd4, 32'h0000_0000);
        add_op(FN_PUSH, 3'd5, -32'sd5);
        add_op(FN_PUSH, 3'd2, 32'h5555_5555);
        add_op(FN_PUSH, 3'd1, 32'haaaa_aaaa);
        repeat (9) add_pop();
        add_op(FN_PUSH, 3'd6, 32'd100);
        add_op(FN_PUSH, 3'd6, 32'd50);
        add_pop();
        add_op(FN_PUSH, 3'd6, 32'd200);
        add_pop();
        add_op(FN_CLEAR, 3'd7, 32'hffff_ffff);
        add_pop();

        // fill one list past full, free three slots, push again
        l = $urandom_range(0, NL - 1);
        repeat (LD + 2) push_sorted(l, 3);
        repeat (3) add_pop();
        repeat (3) push_sorted(l, 3);
        add_op(FN_CLEAR, IDX_W'($urandom_range(0, 7)), $urandom());

        // random phases: mostly sorted pushes and pops, some noise
        while (gen_cnt < 850) begin
            n = $urandom_range(10, 40);
            repeat (n) begin
                r = $urandom_range(0, 99);
                l = $urandom_range(0, NL - 1);
                if (r < 58) push_sorted(l, 1 << 20);
                else if (r < 90) add_pop();
                else if (r < 92) push_out_of_order(l);
                else if (r < 95) add_op(2'd3, IDX_W'($urandom_range(0, 7)), $urandom());
                else add_op(FN_CLEAR, IDX_W'($urandom_range(0, 7)), $urandom());
            end
            if ($urandom_range(0, 1) != 0) begin
                repeat ($urandom_range(1, 30)) add_pop();
            end
            if ($urandom_range(0, 2) != 0) begin
                add_op(FN_CLEAR, IDX_W'($urandom_range(0, 7)), $urandom());
            end
        end

        // reset, then run until everything has come back
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (op_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (NL + 8) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/kwsm_pkg.sv
sv/k_way_sorted_merge.sv
tb/tb.sv
